// ----- rtl/core/lqps_pkg.sv -----
// Package for the longest-queue phase scheduler: command codes, lane and phase
// types, the phase-to-lane tables and the request and response payload structs.
// Depends on nothing; used by longest_queue_phase_scheduler_unit.
package lqps_pkg;

	localparam int NUM_LANES          = 8;
	localparam int NUM_PHASES         = 8;
	localparam int LANE_BITS          = 3;
	localparam int SERVED_BITS        = 8;
	localparam int LIMIT_BITS         = 8;
	localparam int COUNT_BITS_DEFAULT = 8;

	typedef enum logic [1:0] {
		CMD_ARRIVAL       = 2'd0,
		CMD_GREEN_LIMITED = 2'd1,
		CMD_GREEN_CLEAR   = 2'd2,
		CMD_UNUSED        = 2'd3
	} cmd_t;

	typedef logic [LANE_BITS-1:0] lane_idx_t;

	// Phases listed as (first lane, second lane), lanes 0 NF .. 7 WL.
	localparam lane_idx_t PHASE_FIRST [NUM_PHASES] = '{
		3'd4, 3'd2, 3'd0, 3'd6, 3'd4, 3'd2, 3'd5, 3'd3
	};
	localparam lane_idx_t PHASE_SECOND [NUM_PHASES] = '{
		3'd5, 3'd3, 3'd1, 3'd7, 3'd0, 3'd6, 3'd1, 3'd7
	};

	typedef struct packed {
		cmd_t                  cmd;
		lane_idx_t             lane;
		logic [LIMIT_BITS-1:0] remove_count;
	} req_t;

	typedef struct packed {
		logic                   granted;
		lane_idx_t              phase;
		logic [SERVED_BITS-1:0] served_first;
		logic [SERVED_BITS-1:0] served_second;
		logic                   dropped;
	} rsp_t;

endpackage

// ----- rtl/core/longest_queue_phase_scheduler_unit.sv -----
// Top level of the longest-queue phase scheduler: lane counters, phase totals,
// winner selection and lane draining in a single registered pass.
// Depends on lqps_pkg for the payload structs, command codes and phase tables.
//
// Usage
// The request channel (req_valid, req_ready, req) carries one transaction per
// event: an arrival on one lane, or a green command with limited or full drain.
// The response channel (rsp_valid, rsp_ready, rsp) returns exactly one result
// transaction for every request, in order.
// A request is captured in an input register; from there the phase totals, the
// eight-way maximum and the counter updates are evaluated and the result is
// written to the output register. One request is taken every cycle as long as
// the receiver does not stall the output register.
// The lane counters change as the result is registered, so the next request
// always sees the effect of the one before it.
// When the receiver stalls, the output register holds its result and the input
// register holds the following request; req_ready stays high while the input
// register is empty or able to move on.
// Reset clears all lane counters and both valid flags at once.
module longest_queue_phase_scheduler_unit #(
	parameter int COUNT_BITS = lqps_pkg::COUNT_BITS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  lqps_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output lqps_pkg::rsp_t rsp
);

	localparam int WIDE_BITS = (COUNT_BITS > lqps_pkg::LIMIT_BITS) ?
		COUNT_BITS : lqps_pkg::LIMIT_BITS;
	localparam int TOTAL_BITS = COUNT_BITS + 1;

	logic                  valid_s1;
	lqps_pkg::req_t        req_s1;
	logic                  rsp_valid_q;
	lqps_pkg::rsp_t        rsp_q;
	logic [COUNT_BITS-1:0] lane_count_q [lqps_pkg::NUM_LANES];
	logic [COUNT_BITS-1:0] lane_count_d [lqps_pkg::NUM_LANES];
	logic                  advance;
	lqps_pkg::rsp_t        rsp_d;

	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	always_comb begin
		logic [TOTAL_BITS-1:0]  total [lqps_pkg::NUM_PHASES];
		logic [TOTAL_BITS-1:0]  best_total;
		lqps_pkg::lane_idx_t    best;
		lqps_pkg::lane_idx_t    first_lane;
		lqps_pkg::lane_idx_t    second_lane;
		logic [WIDE_BITS-1:0]   limit_w;
		logic [WIDE_BITS-1:0]   take_first;
		logic [WIDE_BITS-1:0]   take_second;
		logic [COUNT_BITS-1:0]  arrival_count;
		logic                   full_clear;

		for (int l = 0; l < lqps_pkg::NUM_LANES; l++) begin
			lane_count_d[l] = lane_count_q[l];
		end
		rsp_d = '0;

		for (int p = 0; p < lqps_pkg::NUM_PHASES; p++) begin
			total[p] = {1'b0, lane_count_q[lqps_pkg::PHASE_FIRST[p]]} +
				{1'b0, lane_count_q[lqps_pkg::PHASE_SECOND[p]]};
		end
		best_total = total[0];
		best       = '0;
		for (int p = 1; p < lqps_pkg::NUM_PHASES; p++) begin
			if (total[p] > best_total) begin
				best_total = total[p];
				best       = lqps_pkg::lane_idx_t'(p);
			end
		end

		first_lane  = lqps_pkg::PHASE_FIRST[best];
		second_lane = lqps_pkg::PHASE_SECOND[best];
		full_clear  = (req_s1.cmd == lqps_pkg::CMD_GREEN_CLEAR);
		limit_w     = WIDE_BITS'(req_s1.remove_count);
		take_first  = WIDE_BITS'(lane_count_q[first_lane]);
		take_second = WIDE_BITS'(lane_count_q[second_lane]);
		if (!full_clear && limit_w < take_first) begin
			take_first = limit_w;
		end
		if (!full_clear && limit_w < take_second) begin
			take_second = limit_w;
		end

		arrival_count = lane_count_q[req_s1.lane];

		unique case (req_s1.cmd) inside
			lqps_pkg::CMD_ARRIVAL: begin
				if (arrival_count == {COUNT_BITS{1'b1}}) begin
					rsp_d.dropped = 1'b1;
				end else begin
					lane_count_d[req_s1.lane] = arrival_count + 1'b1;
				end
			end
			lqps_pkg::CMD_GREEN_LIMITED, lqps_pkg::CMD_GREEN_CLEAR: begin
				rsp_d.granted = 1'b1;
				rsp_d.phase   = best;
				rsp_d.served_first = (take_first > WIDE_BITS'(255)) ?
					8'hFF : take_first[lqps_pkg::SERVED_BITS-1:0];
				rsp_d.served_second = (take_second > WIDE_BITS'(255)) ?
					8'hFF : take_second[lqps_pkg::SERVED_BITS-1:0];
				lane_count_d[first_lane] =
					lane_count_q[first_lane] - COUNT_BITS'(take_first);
				lane_count_d[second_lane] =
					lane_count_q[second_lane] - COUNT_BITS'(take_second);
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < lqps_pkg::NUM_LANES; l++) begin
				lane_count_q[l] <= '0;
			end
		end else if (valid_s1 && advance) begin
			for (int l = 0; l < lqps_pkg::NUM_LANES; l++) begin
				lane_count_q[l] <= lane_count_d[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
